### design/scfp_pkg.sv
// Shared types, constants and the CRC-8 byte update for the sync CRC-8 frame parser.
package scfp_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] CRC_POLY  = 8'h31;
    localparam logic [7:0] CRC_INIT  = 8'hFF;

    localparam int PAYLOAD_LEN     = 6;
    localparam int CNT_W           = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_PARSER_ENABLE = 3'd0;
    localparam logic PARSER_ENABLE_RST = 1'b1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_PAD_W   = 7;

    localparam int VAL_W = 10;
    localparam logic [VAL_W-1:0] RST_YELLOW_ANGLE    = 10'd0;
    localparam logic [VAL_W-1:0] RST_YELLOW_DISTANCE = 10'd100;
    localparam logic [VAL_W-1:0] RST_BLUE_ANGLE      = 10'd180;
    localparam logic [VAL_W-1:0] RST_BLUE_DISTANCE   = 10'd80;
    localparam logic [VAL_W-1:0] RST_BALL_ANGLE      = 10'd0;
    localparam logic [VAL_W-1:0] RST_BALL_DISTANCE   = 10'd0;

    localparam logic [1:0] VIS_BOTH           = 2'd0;
    localparam logic [1:0] VIS_YELLOW_MISSING = 2'd1;
    localparam logic [1:0] VIS_BLUE_MISSING   = 2'd2;
    localparam logic [1:0] VIS_NONE           = 2'd3;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_PAYLOAD,
        ST_CRC
    } front_state_t;

    typedef struct packed {
        logic [PAYLOAD_LEN-1:0][7:0] payload;
    } scfp_frame_t;

    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [1:0]           visibility_status;
        logic                 ball_seen;
        logic [VAL_W-1:0]     ball_distance;
        logic [VAL_W-1:0]     ball_angle;
        logic                 blue_seen;
        logic [VAL_W-1:0]     blue_distance;
        logic [VAL_W-1:0]     blue_angle;
        logic                 yellow_seen;
        logic [VAL_W-1:0]     yellow_distance;
        logic [VAL_W-1:0]     yellow_angle;
    } scfp_result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (v[7])
            begin
                v = (v << 1) ^ CRC_POLY;
            end
            else
            begin
                v = v << 1;
            end
        end
        return v;
    endfunction

endpackage

### design/scfp_front.sv
// Front end: sync hunt, payload capture and CRC check, pushing good frames to the queue.
module scfp_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     parser_enable,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,
    output logic                     push_valid,
    input  logic                     push_ready,
    output scfp_pkg::scfp_frame_t    push_data
);

    localparam logic [scfp_pkg::CNT_W-1:0] LAST_IDX = scfp_pkg::CNT_W'(scfp_pkg::PAYLOAD_LEN - 1);

    scfp_pkg::front_state_t state_reg, state_next;
    logic [scfp_pkg::CNT_W-1:0] count_reg, count_next;
    logic [7:0] crc_reg, crc_next;
    logic [scfp_pkg::PAYLOAD_LEN-1:0][7:0] payload_reg;
    logic take;

    assign take = s_tvalid && s_tready && parser_enable;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        if (take)
        begin
            unique case (state_reg)
                scfp_pkg::ST_HUNT:
                begin
                    if (s_tdata == scfp_pkg::SYNC_BYTE)
                    begin
                        state_next = scfp_pkg::ST_PAYLOAD;
                        count_next = '0;
                        crc_next   = scfp_pkg::CRC_INIT;
                    end
                end
                scfp_pkg::ST_PAYLOAD:
                begin
                    crc_next   = scfp_pkg::crc8_update(crc_reg, s_tdata);
                    count_next = count_reg + 1'b1;
                    if (count_reg == LAST_IDX)
                    begin
                        state_next = scfp_pkg::ST_CRC;
                    end
                end
                scfp_pkg::ST_CRC:
                begin
                    state_next = scfp_pkg::ST_HUNT;
                    count_next = '0;
                    crc_next   = scfp_pkg::CRC_INIT;
                end
                default:
                begin
                    state_next = scfp_pkg::ST_HUNT;
                    count_next = '0;
                    crc_next   = scfp_pkg::CRC_INIT;
                end
            endcase
        end
    end

    always_comb
    begin
        s_tready   = 1'b1;
        push_valid = 1'b0;
        unique case (state_reg)
            scfp_pkg::ST_CRC:
            begin
                s_tready   = !(parser_enable && !push_ready);
                push_valid = take && (s_tdata == crc_reg);
            end
            default:
            begin
                s_tready   = 1'b1;
                push_valid = 1'b0;
            end
        endcase
    end

    assign push_data.payload = payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scfp_pkg::ST_HUNT;
            count_reg <= '0;
            crc_reg   <= scfp_pkg::CRC_INIT;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && state_reg == scfp_pkg::ST_PAYLOAD)
        begin
            payload_reg[count_reg] <= s_tdata;
        end
    end

endmodule

### design/scfp_queue.sv
// Short frame queue between the front end and the result stage.
module scfp_queue #(
    parameter int DEPTH = scfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  scfp_pkg::scfp_frame_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output scfp_pkg::scfp_frame_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

    scfp_pkg::scfp_frame_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic do_push, do_pop;

    assign push_ready = (fill_reg != FULL_FILL);
    assign pop_valid  = (fill_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/scfp_back.sv
// Result stage: held target values, visibility status and the output register.
module scfp_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  scfp_pkg::scfp_frame_t              pop_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [scfp_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    logic [scfp_pkg::VAL_W-1:0] ya_reg, ya_next, yd_reg, yd_next;
    logic [scfp_pkg::VAL_W-1:0] ba_reg, ba_next, bd_reg, bd_next;
    logic [scfp_pkg::VAL_W-1:0] ca_reg, ca_next, cd_reg, cd_next;
    logic ys, bs, cs;
    logic [1:0] status;
    logic out_valid_reg;
    scfp_pkg::scfp_result_t out_reg, out_next;
    logic do_pop;

    assign pop_ready = !out_valid_reg || m_tready;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        ys = (pop_data.payload[1] != 8'd0);
        bs = (pop_data.payload[3] != 8'd0);
        cs = (pop_data.payload[5] != 8'd0);
        ya_next = ys ? {pop_data.payload[0], 2'b00} : ya_reg;
        yd_next = ys ? {pop_data.payload[1], 2'b00} : yd_reg;
        ba_next = bs ? {pop_data.payload[2], 2'b00} : ba_reg;
        bd_next = bs ? {pop_data.payload[3], 2'b00} : bd_reg;
        ca_next = cs ? {pop_data.payload[4], 2'b00} : ca_reg;
        cd_next = cs ? {pop_data.payload[5], 2'b00} : cd_reg;
        case ({ys, bs})
            2'b11:   status = scfp_pkg::VIS_BOTH;
            2'b01:   status = scfp_pkg::VIS_YELLOW_MISSING;
            2'b10:   status = scfp_pkg::VIS_BLUE_MISSING;
            default: status = scfp_pkg::VIS_NONE;
        endcase
        out_next.pad               = '0;
        out_next.visibility_status = status;
        out_next.ball_seen         = cs;
        out_next.ball_distance     = cd_next;
        out_next.ball_angle        = ca_next;
        out_next.blue_seen         = bs;
        out_next.blue_distance     = bd_next;
        out_next.blue_angle        = ba_next;
        out_next.yellow_seen       = ys;
        out_next.yellow_distance   = yd_next;
        out_next.yellow_angle      = ya_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ya_reg <= scfp_pkg::RST_YELLOW_ANGLE;
            yd_reg <= scfp_pkg::RST_YELLOW_DISTANCE;
            ba_reg <= scfp_pkg::RST_BLUE_ANGLE;
            bd_reg <= scfp_pkg::RST_BLUE_DISTANCE;
            ca_reg <= scfp_pkg::RST_BALL_ANGLE;
            cd_reg <= scfp_pkg::RST_BALL_DISTANCE;
        end
        else
        begin
            if (do_pop)
            begin
                out_valid_reg <= 1'b1;
                ya_reg <= ya_next;
                yd_reg <= yd_next;
                ba_reg <= ba_next;
                bd_reg <= bd_next;
                ca_reg <= ca_next;
                cd_reg <= cd_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

### design/sync_crc8_frame_parser_top.sv
// Top level of the sync CRC-8 frame parser: register port, front end, queue and result stage.
//
// Channel   Direction  Handshake                    Payload
// s_*       in         s_tvalid / s_tready          s_tdata: rx_byte
// m_*       out        m_tvalid / m_tready          m_tdata: one decoded frame
// APB       in/out     psel, penable, pwrite        parser_enable at byte address 0
//
// One byte is taken per cycle while s_tready is high, and the front end's CRC update is
// one unrolled byte step. A frame's result is written into the queue on its CRC byte
// transfer, then moves to the output register, which raises m_tvalid, once that is free.
// s_tready drops only on a CRC byte while the queue is full.
// Reset is asynchronous and immediate; no clearing pass is needed.
module sync_crc8_frame_parser_top #(
    parameter int QUEUE_DEPTH = scfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scfp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [scfp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [scfp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] rx_byte
    input  logic [scfp_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] yellow_angle, [19:10] yellow_distance, [20] yellow_seen,
    // [30:21] blue_angle, [40:31] blue_distance, [41] blue_seen,
    // [51:42] ball_angle, [61:52] ball_distance, [62] ball_seen,
    // [64:63] visibility_status, [71:65] zero
    output logic [scfp_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic enable_reg;
    logic push_valid, push_ready, pop_valid, pop_ready;
    scfp_pkg::scfp_frame_t push_data, pop_data;

    assign pready = 1'b1;
    assign prdata = (paddr == scfp_pkg::ADDR_PARSER_ENABLE) ?
                    {{(scfp_pkg::APB_DATA_W-1){1'b0}}, enable_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= scfp_pkg::PARSER_ENABLE_RST;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr == scfp_pkg::ADDR_PARSER_ENABLE)
        begin
            enable_reg <= pwdata[0];
        end
    end

    scfp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .parser_enable (enable_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    scfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    scfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### design/scfp_checker.sv
// Port-level checker for the sync CRC-8 frame parser, bound to the top level.
module scfp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [scfp_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[64:63] == {!m_tdata[41], !m_tdata[20]})
        else $error("visibility status disagrees with seen flags");

    a_seen_dist: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[20] |-> m_tdata[19:10] != 10'd0)
        else $error("yellow seen with zero distance");

    a_scaled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[71:65] == 7'd0 && m_tdata[11:10] == 2'd0 &&
                     m_tdata[32:31] == 2'd0 && m_tdata[53:52] == 2'd0)
        else $error("padding or scaled distance bits nonzero");

endmodule

bind sync_crc8_frame_parser_top scfp_checker u_scfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
